// ===== rtl/core/fde_pkg.sv =====
// shared types and constants for the feedback echo delay line
// no dependencies; imported by every module of the block
package fde_pkg;

    localparam int SAMPLE_W = 8;

    typedef logic [SAMPLE_W-1:0]        t_sample;
    typedef logic signed [SAMPLE_W:0]   t_term;      // centred sample, -128..127
    typedef logic signed [SAMPLE_W+8:0] t_product;   // term times gain
    typedef logic [SAMPLE_W+7:0]        t_magnitude; // |product|, at most 32640

    localparam t_sample MID_SCALE = 8'd127;
    localparam t_term   LIMIT_POS = 9'sd127;
    localparam t_term   LIMIT_NEG = -9'sd127;

    // floor(x / 255) = ((x + 1) * 257) >> 16 for x below 65535
    localparam logic [8:0] RECIP_255 = 9'd257;

endpackage

// ===== rtl/core/fde_mem.sv =====
// delay store: simple dual-port synchronous ram, one write and one registered read
// depends on fde_pkg for the sample type
module fde_mem #(
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output fde_pkg::t_sample         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  fde_pkg::t_sample         i_wr_data
);
    import fde_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/feedback_echo_delay_line.sv =====
// feedback echo delay line: one sample transaction per cycle, sustained while the output is not stalled
// an accepted input transaction yields its result after passing through
// four register stages (ram read, multiply, reciprocal divide, mix and limit)
// reset: synchronous, clears control and the write index; the ram is not swept,
// a fill flag makes entries not yet written in the first pass read as mid-scale
module feedback_echo_delay_line #(
    parameter int DELAY_DEPTH = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fde_pkg::t_sample i_new_sample,
    input  fde_pkg::t_sample i_echo_gain,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fde_pkg::t_sample o_out_sample
);
    import fde_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);

    // write index and first-pass tracking
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic          r_filled, n_filled;

    // stage 1: ram data arrives
    logic          r_s1_v;
    logic          r_s1_blank;   // entry not yet written since reset
    t_sample       r_s1_sample;
    t_sample       r_s1_gain;
    logic [AW-1:0] r_s1_addr;

    // stage 2: product
    logic          r_s2_v;
    t_product      r_s2_prod;
    t_sample       r_s2_sample;
    logic [AW-1:0] r_s2_addr;

    // stage 3: delayed term
    logic          r_s3_v;
    t_term         r_s3_delayed;
    t_sample       r_s3_sample;
    logic [AW-1:0] r_s3_addr;

    // output register
    logic          r_out_v;
    t_sample       r_out_sample;

    // handshake, each stage moves on when the next one is empty or moving
    logic w_out_free, w_mv3, w_free3, w_mv2, w_free2, w_mv1, w_free1, w_accept;

    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_mv3      = r_s3_v && w_out_free;
    assign w_free3    = !r_s3_v || w_mv3;
    assign w_mv2      = r_s2_v && w_free3;
    assign w_free2    = !r_s2_v || w_mv2;
    assign w_mv1      = r_s1_v && w_free2;
    assign w_free1    = !r_s1_v || w_mv1;
    assign w_accept   = i_in_valid && w_free1;

    assign o_in_stall = !w_free1;

    // delay store; read and write of one entry are DELAY_DEPTH transactions apart,
    // far more than the three held in stages 1 to 3 before write-back, so no forwarding is needed
    t_sample w_rd_data;
    t_sample w_result;

    fde_mem #(
        .DEPTH (DELAY_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_wr_idx),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mv3),
        .i_wr_addr (r_s3_addr),
        .i_wr_data (w_result)
    );

    // index advance with wrap, fill flag set at the first wrap
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_filled = r_filled;
        if (w_accept) begin
            if (r_wr_idx == LAST_IDX) begin
                n_wr_idx = '0;
                n_filled = 1'b1;
            end else begin
                n_wr_idx = r_wr_idx + AW'(1);
            end
        end
    end

    // stage 1 arithmetic: centre the stored sample and scale by the gain
    t_sample                 w_stored;
    t_term                   w_diff;
    logic signed [SAMPLE_W+9:0] w_prod_full;

    always_comb begin
        w_stored    = r_s1_blank ? MID_SCALE : w_rd_data;
        w_diff      = $signed({1'b0, MID_SCALE}) - $signed({1'b0, w_stored});
        w_prod_full = w_diff * $signed({1'b0, r_s1_gain});
    end

    // stage 2 arithmetic: divide by 255 toward zero via magnitude and reciprocal
    logic       w_neg;
    t_magnitude w_mag;
    logic [16:0] w_mag_inc;
    logic [24:0] w_scaled;
    logic [7:0]  w_quot;
    t_term      w_delayed;

    always_comb begin
        w_neg     = r_s2_prod[SAMPLE_W+8];
        w_mag     = w_neg ? t_magnitude'(-r_s2_prod) : t_magnitude'(r_s2_prod);
        w_mag_inc = {1'b0, w_mag} + 17'd1;
        w_scaled  = {8'd0, w_mag_inc} * {16'd0, RECIP_255};
        w_quot    = w_scaled[23:16];
        w_delayed = w_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    end

    // stage 3 arithmetic: mix with the new sample, limit, back to offset binary
    t_term                 w_fresh;
    logic signed [SAMPLE_W+1:0] w_sum;
    t_term                 w_limited;

    always_comb begin
        w_fresh = $signed({1'b0, MID_SCALE}) - $signed({1'b0, r_s3_sample});
        w_sum   = 10'(w_fresh) + 10'(r_s3_delayed);
        priority if (w_sum > 10'(LIMIT_POS)) begin
            w_limited = LIMIT_POS;
        end else if (w_sum < 10'(LIMIT_NEG)) begin
            w_limited = LIMIT_NEG;
        end else begin
            w_limited = t_term'(w_sum);
        end
        w_result = t_sample'(w_limited + $signed({1'b0, MID_SCALE}));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_filled <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_filled <= n_filled;
            if (w_free1) begin
                r_s1_v <= w_accept;
            end
            if (w_free2) begin
                r_s2_v <= w_mv1;
            end
            if (w_free3) begin
                r_s3_v <= w_mv2;
            end
            if (w_out_free) begin
                r_out_v <= w_mv3;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_blank  <= !r_filled;
            r_s1_sample <= i_new_sample;
            r_s1_gain   <= i_echo_gain;
            r_s1_addr   <= r_wr_idx;
        end
        if (w_mv1) begin
            r_s2_prod   <= w_prod_full[SAMPLE_W+8:0];
            r_s2_sample <= r_s1_sample;
            r_s2_addr   <= r_s1_addr;
        end
        if (w_mv2) begin
            r_s3_delayed <= w_delayed;
            r_s3_sample  <= r_s2_sample;
            r_s3_addr    <= r_s2_addr;
        end
        if (w_mv3) begin
            r_out_sample <= w_result;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_out_sample = r_out_sample;

endmodule

// ===== rtl/core/fde_chk.sv =====
// port-level checker for the feedback echo delay line, with its bind
// depends on fde_pkg and on the top level's port list
module fde_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input fde_pkg::t_sample i_new_sample,
    input fde_pkg::t_sample i_echo_gain,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input fde_pkg::t_sample o_out_sample
);
    import fde_pkg::*;

    // a stalled input transaction stays offered with the same payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_new_sample) && $stable(i_echo_gain))
        else $error("input changed while stalled");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_sample))
        else $error("result changed while stalled");

    // the limiter keeps the output within 0..254
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_sample != 8'hFF)
        else $error("output beyond limited range");

    // input back-pressure only when the output side is holding a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

endmodule

bind feedback_echo_delay_line fde_chk u_fde_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_new_sample (i_new_sample),
    .i_echo_gain  (i_echo_gain),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_sample (o_out_sample)
);
